// ----- design/fla_pkg.sv -----
`default_nettype none
package fla_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int PTR_W       = $clog2(NUM_ENTRIES);
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 5;

    localparam logic [IDX_W-1:0] WB_IDX    = IDX_W'(NUM_ENTRIES);
    localparam logic [IDX_W-1:0] LOCAL_IDX = IDX_W'(NUM_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(NUM_ENTRIES);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(NUM_ENTRIES - 1);

    localparam logic       FUNC_ALLOC = 1'b0;
    localparam logic       FUNC_FREE  = 1'b1;

    localparam logic [1:0] REQ_NORMAL = 2'd0;
    localparam logic [1:0] REQ_WB     = 2'd1;
    localparam logic [1:0] REQ_LOCAL  = 2'd2;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_NONE     = 2'd1;
    localparam logic [1:0] ERR_BAD_FREE = 2'd2;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    typedef struct packed {
        logic             func;
        logic [1:0]       req_type;
        logic [IDX_W-1:0] freed_entry;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] granted_entry;
        logic             granted;
        logic [1:0]       error_code;
        logic [CNT_W-1:0] free_count;
        logic             normal_avail;
        logic             wb_avail;
        logic             local_avail;
    } t_rsp;

endpackage
`default_nettype wire

// ----- design/fla_ram.sv -----
`default_nettype none
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- design/free_list_allocator_with_reserves.sv -----
// Result: the strobe o_valid is registered from the EXEC state that the accepting edge enters.
// A new command is not accepted while busy; busy covers the cycle in which the
//   free-list RAM read of the head slot returns (registered read).
// Reset: synchronous, active low. The free list reads as 0..NUM_ENTRIES-1 right after
//   reset through per-slot written bits; no fill pass. Results cannot be stalled.
`default_nettype none
module free_list_allocator_with_reserves (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire fla_pkg::t_cmd i_cmd,
    output logic               o_valid,
    output fla_pkg::t_rsp      o_rsp
);

    logic                          r_state;
    fla_pkg::t_cmd                 r_cmd;
    logic [fla_pkg::PTR_W-1:0]     r_head;
    logic [fla_pkg::PTR_W-1:0]     r_tail;
    logic [fla_pkg::CNT_W-1:0]     r_count;
    logic                          r_wb_free;
    logic                          r_local_free;
    logic [fla_pkg::NUM_ENTRIES-1:0] r_in_fifo;
    logic [fla_pkg::NUM_ENTRIES-1:0] r_written;
    logic                          r_rd_written;
    logic [fla_pkg::PTR_W-1:0]     r_rd_dflt;
    logic [fla_pkg::IDX_W-1:0]     ram_q;

    logic                          n_state;
    logic [fla_pkg::PTR_W-1:0]     n_head;
    logic [fla_pkg::PTR_W-1:0]     n_tail;
    logic [fla_pkg::CNT_W-1:0]     n_count;
    logic                          n_wb_free;
    logic                          n_local_free;
    logic [fla_pkg::NUM_ENTRIES-1:0] n_in_fifo;
    logic [fla_pkg::NUM_ENTRIES-1:0] n_written;
    fla_pkg::t_rsp                 n_rsp;
    logic                          push;
    logic [fla_pkg::IDX_W-1:0]     head_val;

    assign busy = (r_state == fla_pkg::ST_EXEC);

    // head slot is always being read; unwritten slots read as their own address
    fla_ram #(
        .WIDTH (fla_pkg::IDX_W),
        .DEPTH (fla_pkg::NUM_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_tail),
        .i_wdata (r_cmd.freed_entry),
        .i_raddr (r_head),
        .o_rdata (ram_q)
    );

    assign head_val = r_rd_written ? ram_q
                                   : fla_pkg::IDX_W'(r_rd_dflt);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_wb_free    = r_wb_free;
        n_local_free = r_local_free;
        n_in_fifo    = r_in_fifo;
        n_written    = r_written;
        push         = 1'b0;
        n_rsp        = '0;

        if (r_state == fla_pkg::ST_IDLE) begin
            if (start) begin
                n_state = fla_pkg::ST_EXEC;
            end
        end else begin
            n_state = fla_pkg::ST_IDLE;
            if (r_cmd.func == fla_pkg::FUNC_ALLOC) begin
                if (r_count != '0) begin
                    n_rsp.granted_entry = head_val;
                    n_rsp.granted       = 1'b1;
                    if (head_val < fla_pkg::WB_IDX) begin
                        n_in_fifo[head_val[fla_pkg::PTR_W-1:0]] = 1'b0;
                    end
                    n_head  = (r_head == fla_pkg::PTR_LAST) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end else if (r_cmd.req_type == fla_pkg::REQ_WB && r_wb_free) begin
                    n_wb_free           = 1'b0;
                    n_rsp.granted_entry = fla_pkg::WB_IDX;
                    n_rsp.granted       = 1'b1;
                end else if (r_cmd.req_type == fla_pkg::REQ_LOCAL && r_local_free) begin
                    n_local_free        = 1'b0;
                    n_rsp.granted_entry = fla_pkg::LOCAL_IDX;
                    n_rsp.granted       = 1'b1;
                end else begin
                    n_rsp.error_code = fla_pkg::ERR_NONE;
                end
            end else begin
                if (r_cmd.freed_entry == fla_pkg::WB_IDX) begin
                    if (r_wb_free) begin
                        n_rsp.error_code = fla_pkg::ERR_BAD_FREE;
                    end else begin
                        n_wb_free = 1'b1;
                    end
                end else if (r_cmd.freed_entry == fla_pkg::LOCAL_IDX) begin
                    if (r_local_free) begin
                        n_rsp.error_code = fla_pkg::ERR_BAD_FREE;
                    end else begin
                        n_local_free = 1'b1;
                    end
                end else if (r_cmd.freed_entry < fla_pkg::WB_IDX) begin
                    if (r_in_fifo[r_cmd.freed_entry[fla_pkg::PTR_W-1:0]]
                            || r_count >= fla_pkg::CNT_FULL) begin
                        n_rsp.error_code = fla_pkg::ERR_BAD_FREE;
                    end else begin
                        push                = 1'b1;
                        n_written[r_tail]   = 1'b1;
                        n_tail  = (r_tail == fla_pkg::PTR_LAST) ? '0 : r_tail + 1'b1;
                        n_count = r_count + 1'b1;
                        n_in_fifo[r_cmd.freed_entry[fla_pkg::PTR_W-1:0]] = 1'b1;
                    end
                end else begin
                    n_rsp.error_code = fla_pkg::ERR_BAD_FREE;
                end
            end
            n_rsp.free_count   = n_count;
            n_rsp.normal_avail = (n_count != '0);
            n_rsp.wb_avail     = (n_count != '0) || n_wb_free;
            n_rsp.local_avail  = (n_count != '0) || n_local_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fla_pkg::ST_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= fla_pkg::CNT_FULL;
            r_wb_free    <= 1'b1;
            r_local_free <= 1'b1;
            r_in_fifo    <= '1;
            r_written    <= '0;
            o_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_wb_free    <= n_wb_free;
            r_local_free <= n_local_free;
            r_in_fifo    <= n_in_fifo;
            r_written    <= n_written;
            o_valid      <= (r_state == fla_pkg::ST_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fla_pkg::ST_IDLE && start) begin
            r_cmd <= i_cmd;
        end
        r_rd_written <= r_written[r_head];
        r_rd_dflt    <= r_head;
        o_rsp        <= n_rsp;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fla_pkg::CNT_FULL)
        else $error("free count above table size");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_in_fifo) == int'(r_count))
        else $error("free-list membership disagrees with count");

    a_beat_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted command produced no result beat");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.granted) |-> (o_rsp.error_code == fla_pkg::ERR_OK))
        else $error("grant carries an error code");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_count < fla_pkg::CNT_FULL))
        else $error("push into full free list");

endmodule
`default_nettype wire

// ----- verif/free_list_checker.sv -----
`default_nettype none
module free_list_checker
    import fla_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_busy,
    input  wire t_cmd i_cmd,
    input  wire logic i_valid,
    input  wire t_rsp i_rsp,
    output int        o_pending,
    output int        o_fail_cnt
);

    // shadow copy of the allocator state
    logic [IDX_W-1:0]       fl_slot [NUM_ENTRIES];
    logic [PTR_W-1:0]       fl_head;
    logic [PTR_W-1:0]       fl_tail;
    logic [CNT_W-1:0]       fl_count;
    logic [NUM_ENTRIES-1:0] fl_queued;
    logic                   wb_res_free;
    logic                   loc_res_free;

    t_rsp rsp_due [$];
    t_rsp want;

    task automatic report(string what, int unsigned got, int unsigned exp_val);
        o_fail_cnt++;
        // keep the log short if the block is badly broken
        if (o_fail_cnt <= 100)
            $display("chk: %s: got %0d, want %0d", what, got, exp_val);
    endtask

    function automatic t_rsp alloc_free_step(input t_cmd c);
        t_rsp r;
        r = '0;
        if (c.func == FUNC_ALLOC) begin
            if (fl_count != 0) begin
                r.granted_entry = fl_slot[fl_head];
                r.granted = 1'b1;
                fl_queued[fl_slot[fl_head]] = 1'b0;
                fl_head = (fl_head == PTR_LAST) ? '0 : fl_head + 1'b1;
                fl_count--;
            end else if (c.req_type == REQ_WB && wb_res_free) begin
                wb_res_free = 1'b0;
                r.granted_entry = WB_IDX;
                r.granted = 1'b1;
            end else if (c.req_type == REQ_LOCAL && loc_res_free) begin
                loc_res_free = 1'b0;
                r.granted_entry = LOCAL_IDX;
                r.granted = 1'b1;
            end else begin
                r.error_code = ERR_NONE;
            end
        end else begin
            if (c.freed_entry == WB_IDX) begin
                if (wb_res_free)
                    r.error_code = ERR_BAD_FREE;
                else
                    wb_res_free = 1'b1;
            end else if (c.freed_entry == LOCAL_IDX) begin
                if (loc_res_free)
                    r.error_code = ERR_BAD_FREE;
                else
                    loc_res_free = 1'b1;
            end else if (c.freed_entry < NUM_ENTRIES) begin
                if (fl_queued[c.freed_entry] || fl_count >= CNT_FULL) begin
                    r.error_code = ERR_BAD_FREE;
                end else begin
                    fl_slot[fl_tail] = c.freed_entry;
                    fl_tail = (fl_tail == PTR_LAST) ? '0 : fl_tail + 1'b1;
                    fl_count++;
                    fl_queued[c.freed_entry] = 1'b1;
                end
            end else begin
                r.error_code = ERR_BAD_FREE;
            end
        end
        r.free_count   = fl_count;
        r.normal_avail = (fl_count != 0);
        r.wb_avail     = (fl_count != 0) || wb_res_free;
        r.local_avail  = (fl_count != 0) || loc_res_free;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ENTRIES; k++)
                fl_slot[k] = IDX_W'(k);
            fl_head = '0;
            fl_tail = '0;
            fl_count = CNT_FULL;
            fl_queued = '1;
            wb_res_free = 1'b1;
            loc_res_free = 1'b1;
            o_fail_cnt = 0;
            rsp_due.delete();
        end else begin
            // results come from commands accepted on earlier edges, so check before queuing
            if (i_valid) begin
                if (rsp_due.size() == 0) begin
                    report("result beat with nothing outstanding", 32'(i_rsp), 0);
                end else begin
                    want = rsp_due[0];
                    rsp_due.delete(0);
                    if (i_rsp.granted_entry !== want.granted_entry)
                        report("granted_entry", 32'(i_rsp.granted_entry),
                               32'(want.granted_entry));
                    if (i_rsp.granted !== want.granted)
                        report("granted", 32'(i_rsp.granted), 32'(want.granted));
                    if (i_rsp.error_code !== want.error_code)
                        report("error_code", 32'(i_rsp.error_code), 32'(want.error_code));
                    if (i_rsp.free_count !== want.free_count)
                        report("free_count", 32'(i_rsp.free_count), 32'(want.free_count));
                    if (i_rsp.normal_avail !== want.normal_avail)
                        report("normal_avail", 32'(i_rsp.normal_avail),
                               32'(want.normal_avail));
                    if (i_rsp.wb_avail !== want.wb_avail)
                        report("wb_avail", 32'(i_rsp.wb_avail), 32'(want.wb_avail));
                    if (i_rsp.local_avail !== want.local_avail)
                        report("local_avail", 32'(i_rsp.local_avail),
                               32'(want.local_avail));
                end
            end
            if (i_start && !i_busy)
                rsp_due.insert(rsp_due.size(), alloc_free_step(i_cmd));
        end
        o_pending = rsp_due.size();
    end

endmodule
`default_nettype wire

// ----- verif/tb_free_list_allocator_with_reserves.sv -----
`default_nettype none
module tb_free_list_allocator_with_reserves;
    import fla_pkg::*;

    localparam int MAX_CYCLES = 200000;
    localparam int RAND_PER_PHASE = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_cmd cmd_bus = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;
    int   pending;
    int   fail_cnt;

    int idle_pct_by_phase [4] = '{0, 84, 0, 28};

    initial forever #1 i_clk = ~i_clk;

    free_list_allocator_with_reserves i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd_bus),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    free_list_checker i_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_cmd      (cmd_bus),
        .i_valid    (o_valid),
        .i_rsp      (o_rsp),
        .o_pending  (pending),
        .o_fail_cnt (fail_cnt)
    );

    function automatic t_cmd make_cmd(logic f, logic [1:0] rt, logic [IDX_W-1:0] e);
        t_cmd c;
        c.func = f;
        c.req_type = rt;
        c.freed_entry = e;
        return c;
    endfunction

    // one command beat; start stays high across back-to-back beats
    task automatic issue(t_cmd c, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            cmd_bus <= t_cmd'($urandom);
        end
        @(negedge i_clk);
        start <= 1'b1;
        cmd_bus <= c;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
    endtask

    initial begin
        repeat (MAX_CYCLES) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int alloc_pct;
        int idle_pct;
        t_cmd c;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: duplicate free into a full list, drain it, then the reserves
        issue(make_cmd(FUNC_FREE, REQ_NORMAL, 5'd0), 0);
        for (int k = 0; k < NUM_ENTRIES; k++)
            issue(make_cmd(FUNC_ALLOC, 2'(k), 5'(31 - k)), 0);
        issue(make_cmd(FUNC_ALLOC, REQ_NORMAL, '0), 0);
        issue(make_cmd(FUNC_ALLOC, 2'd3, '1), 0);
        issue(make_cmd(FUNC_ALLOC, REQ_WB, '0), 0);
        issue(make_cmd(FUNC_ALLOC, REQ_WB, '0), 0);
        issue(make_cmd(FUNC_ALLOC, REQ_LOCAL, '0), 0);
        issue(make_cmd(FUNC_ALLOC, REQ_LOCAL, '0), 0);
        issue(make_cmd(FUNC_FREE, 2'd3, 5'd31), 0);
        issue(make_cmd(FUNC_FREE, REQ_NORMAL, WB_IDX), 0);
        issue(make_cmd(FUNC_FREE, REQ_NORMAL, WB_IDX), 0);
        issue(make_cmd(FUNC_FREE, REQ_LOCAL, LOCAL_IDX), 0);
        issue(make_cmd(FUNC_FREE, REQ_LOCAL, LOCAL_IDX), 0);
        issue(make_cmd(FUNC_FREE, REQ_WB, 5'd15), 0);
        issue(make_cmd(FUNC_FREE, REQ_WB, 5'd15), 0);

        // random: allocate/free mix shifts every 50 beats to sweep fill levels
        alloc_pct = 50;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = idle_pct_by_phase[ph];
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (n % 50 == 0)
                    alloc_pct = $urandom_range(85, 15);
                c.func = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
                c.req_type = 2'($urandom_range(3));
                // mostly legal indices, some out of range
                if ($urandom_range(9) < 8)
                    c.freed_entry = IDX_W'($urandom_range(LOCAL_IDX));
                else
                    c.freed_entry = IDX_W'($urandom);
                issue(c, idle_pct);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

// ----- free_list_allocator_with_reserves.f -----
design/fla_pkg.sv
design/fla_ram.sv
design/free_list_allocator_with_reserves.sv
verif/free_list_checker.sv
verif/tb_free_list_allocator_with_reserves.sv
